// ----- hw/rtl/dqpp_pkg.sv -----
// Package with character codes and status codes for the dotted-quad parser.
`timescale 1ns / 1ps
`default_nettype none

package dqpp_pkg;

  localparam int CHAR_W = 8;
  localparam int ACC_W  = 16;
  localparam int OCT_W  = 8;

  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [ACC_W-1:0] OCT_MAX = 16'd255;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NODOT = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  function automatic logic [ACC_W-1:0] times_ten_add(input logic [ACC_W-1:0] acc,
                                                     input logic [3:0] digit);
    times_ten_add = {acc[ACC_W-4:0], 3'b000} + {acc[ACC_W-2:0], 1'b0}
                    + {{(ACC_W-4){1'b0}}, digit};
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dotted_quad_port_parser_core.sv -----
// Dotted-quad address and port parser: one character word in, one result word per parse.
// Throughput: one character word per cycle while results are taken.
// Characters pass an input register, then one combinational step into the result register.
// Reset: parser idle, both stages empty, default port cleared to zero.
`timescale 1ns / 1ps
`default_nettype none

module dotted_quad_port_parser_core
  import dqpp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [ACC_W-1:0]  cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CHAR_W-1:0] char_in,
  input  wire logic              first,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [OCT_W-1:0]       octet_a,
  output logic [OCT_W-1:0]       octet_b,
  output logic [OCT_W-1:0]       octet_c,
  output logic [OCT_W-1:0]       octet_d,
  output logic [ACC_W-1:0]       port_out,
  output logic [1:0]             status
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_F1,
    PH_F2,
    PH_F3,
    PH_F4,
    PH_PORT
  } phase_t;

  logic [ACC_W-1:0]  default_port;
  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic              s1_first;

  phase_t            phase, phase_next;
  logic [ACC_W-1:0]  acc, acc_next;
  logic [OCT_W-1:0]  oct_a, oct_a_next;
  logic [OCT_W-1:0]  oct_b, oct_b_next;
  logic [OCT_W-1:0]  oct_c, oct_c_next;
  logic [OCT_W-1:0]  last_oct, last_oct_next;
  logic              range_flag, range_flag_next;

  logic              s1_go;
  logic              emit;
  status_t           emit_status;
  logic [OCT_W-1:0]  emit_d;
  logic [ACC_W-1:0]  emit_port;

  phase_t            ph;
  logic [ACC_W-1:0]  acc_cur;
  logic              rflag_cur;
  logic              is_digit;
  logic              acc_big;

  assign s1_go    = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_comb begin
    ph        = s1_first ? PH_F1 : phase;
    acc_cur   = s1_first ? '0 : acc;
    rflag_cur = s1_first ? 1'b0 : range_flag;
    is_digit  = (s1_char >= CH_ZERO) && (s1_char <= CH_NINE);
    acc_big   = acc_cur > OCT_MAX;

    phase_next      = ph;
    acc_next        = acc_cur;
    oct_a_next      = s1_first ? '0 : oct_a;
    oct_b_next      = s1_first ? '0 : oct_b;
    oct_c_next      = s1_first ? '0 : oct_c;
    last_oct_next   = s1_first ? '0 : last_oct;
    range_flag_next = rflag_cur;
    emit            = 1'b0;
    emit_status     = ST_OK;
    emit_d          = '0;
    emit_port       = '0;

    if (ph != PH_IDLE) begin
      if (is_digit) begin
        acc_next = times_ten_add(acc_cur, 4'(s1_char - CH_ZERO));
      end else begin
        unique case (ph)
          PH_F1, PH_F2, PH_F3: begin
            if (s1_char != CH_DOT) begin
              emit        = 1'b1;
              emit_status = ST_NODOT;
              phase_next  = PH_IDLE;
            end else begin
              range_flag_next = rflag_cur | acc_big;
              if (ph == PH_F1) oct_a_next = acc_cur[OCT_W-1:0];
              if (ph == PH_F2) oct_b_next = acc_cur[OCT_W-1:0];
              if (ph == PH_F3) oct_c_next = acc_cur[OCT_W-1:0];
              acc_next   = '0;
              phase_next = (ph == PH_F1) ? PH_F2 : (ph == PH_F2) ? PH_F3 : PH_F4;
            end
          end
          PH_F4: begin
            if (rflag_cur || acc_big) begin
              emit        = 1'b1;
              emit_status = ST_RANGE;
              phase_next  = PH_IDLE;
            end else begin
              last_oct_next = acc_cur[OCT_W-1:0];
              acc_next      = '0;
              if (s1_char == CH_COLON) begin
                phase_next = PH_PORT;
              end else begin
                emit        = 1'b1;
                emit_status = ST_OK;
                emit_d      = acc_cur[OCT_W-1:0];
                emit_port   = default_port;
                phase_next  = PH_IDLE;
              end
            end
          end
          PH_PORT: begin
            emit        = 1'b1;
            emit_status = ST_OK;
            emit_d      = last_oct;
            emit_port   = acc_cur;
            phase_next  = PH_IDLE;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_port <= '0;
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      phase        <= PH_IDLE;
      acc          <= '0;
      range_flag   <= 1'b0;
      oct_a        <= '0;
      oct_b        <= '0;
      oct_c        <= '0;
      last_oct     <= '0;
    end else begin
      if (cfg_we) default_port <= cfg_wdata;

      if (in_ready) begin
        s1_valid <= in_valid;
        s1_char  <= char_in;
        s1_first <= first;
      end

      if (s1_go && emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (s1_go) begin
        phase      <= phase_next;
        acc        <= acc_next;
        range_flag <= range_flag_next;
        oct_a      <= oct_a_next;
        oct_b      <= oct_b_next;
        oct_c      <= oct_c_next;
        last_oct   <= last_oct_next;
        if (emit) begin
          status    <= emit_status;
          if (emit_status == ST_OK) begin
            octet_a  <= oct_a_next;
            octet_b  <= oct_b_next;
            octet_c  <= oct_c_next;
            octet_d  <= emit_d;
            port_out <= emit_port;
          end else begin
            octet_a  <= '0;
            octet_b  <= '0;
            octet_c  <= '0;
            octet_d  <= '0;
            port_out <= '0;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for the dotted-quad address and port parser core.
`timescale 1ns / 1ps

module tb;
  import dqpp_pkg::*;

  localparam int RUN_LIMIT = 200000;
  localparam int WORDS_PER_MODE = 375;

  typedef enum logic [2:0] {
    PH_IDLE, PH_A, PH_B, PH_C, PH_D, PH_PORT
  } parse_phase_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              lead;
  } char_word_t;

  typedef struct {
    logic [OCT_W-1:0] a;
    logic [OCT_W-1:0] b;
    logic [OCT_W-1:0] c;
    logic [OCT_W-1:0] d;
    logic [ACC_W-1:0] port;
    status_t          st;
  } addr_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [ACC_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CHAR_W-1:0] char_in = '0;
  logic first = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OCT_W-1:0] octet_a, octet_b, octet_c, octet_d;
  logic [ACC_W-1:0] port_out;
  logic [1:0] status;

  char_word_t   char_q[$];
  addr_result_t addr_q[$];
  char_word_t   next_word;
  addr_result_t got_want;
  logic         in_taken = 1'b0;
  logic         lead_pending = 1'b0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           stim_cnt = 0;
  int           err_cnt = 0;
  int           char_cnt = 0;
  int           ok_cnt = 0;
  int           nodot_cnt = 0;
  int           range_cnt = 0;
  int           cycle_cnt = 0;

  // parser shadow state
  parse_phase_t     ps_phase = PH_IDLE;
  logic [ACC_W-1:0] ps_acc = '0;
  logic [OCT_W-1:0] held_a = '0;
  logic [OCT_W-1:0] held_b = '0;
  logic [OCT_W-1:0] held_c = '0;
  logic             ps_over = 1'b0;
  logic [OCT_W-1:0] held_d = '0;
  logic [ACC_W-1:0] port_default = '0;

  dotted_quad_port_parser_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .char_in(char_in), .first(first),
    .out_valid(out_valid), .out_ready(out_ready),
    .octet_a(octet_a), .octet_b(octet_b), .octet_c(octet_c), .octet_d(octet_d),
    .port_out(port_out), .status(status)
  );

  initial forever #4 clk = ~clk;

  task flag_error(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  task close_parse(input logic [OCT_W-1:0] d, input logic [ACC_W-1:0] p, input status_t st);
    addr_result_t r;
    if (st == ST_OK) begin
      r.a = held_a;
      r.b = held_b;
      r.c = held_c;
      r.d = d;
      r.port = p;
    end else begin
      r.a = '0;
      r.b = '0;
      r.c = '0;
      r.d = '0;
      r.port = '0;
    end
    r.st = st;
    addr_q.push_back(r);
    ps_phase = PH_IDLE;
  endtask

  task parse_char(input logic [CHAR_W-1:0] ch, input logic lead);
    if (lead) begin
      ps_phase = PH_A;
      ps_acc = '0;
      held_a = '0;
      held_b = '0;
      held_c = '0;
      ps_over = 1'b0;
      held_d = '0;
    end
    if (ps_phase != PH_IDLE) begin
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        ps_acc = ps_acc * 16'd10 + {8'd0, ch - CH_ZERO};
      end else if (ps_phase == PH_A || ps_phase == PH_B || ps_phase == PH_C) begin
        if (ch != CH_DOT) begin
          close_parse('0, '0, ST_NODOT);
        end else begin
          if (ps_acc > OCT_MAX) ps_over = 1'b1;
          case (ps_phase)
            PH_A: begin
              held_a = ps_acc[OCT_W-1:0];
              ps_phase = PH_B;
            end
            PH_B: begin
              held_b = ps_acc[OCT_W-1:0];
              ps_phase = PH_C;
            end
            default: begin
              held_c = ps_acc[OCT_W-1:0];
              ps_phase = PH_D;
            end
          endcase
          ps_acc = '0;
        end
      end else if (ps_phase == PH_D) begin
        if (ps_over || ps_acc > OCT_MAX) begin
          close_parse('0, '0, ST_RANGE);
        end else begin
          held_d = ps_acc[OCT_W-1:0];
          ps_acc = '0;
          if (ch == CH_COLON) ps_phase = PH_PORT;
          else close_parse(held_d, port_default, ST_OK);
        end
      end else begin
        close_parse(held_d, ps_acc, ST_OK);
      end
    end
  endtask

  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_word = char_q.pop_front();
        in_valid <= 1'b1;
        char_in <= next_word.ch;
        first <= next_word.lead;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) begin
        parse_char(char_in, first);
        char_cnt++;
      end
      if (out_valid && out_ready) begin
        if (addr_q.size() == 0) begin
          flag_error($sformatf("result with nothing pending, status %0d", status));
        end else begin
          got_want = addr_q.pop_front();
          if (octet_a !== got_want.a)
            flag_error($sformatf("octet_a got %0d want %0d", octet_a, got_want.a));
          if (octet_b !== got_want.b)
            flag_error($sformatf("octet_b got %0d want %0d", octet_b, got_want.b));
          if (octet_c !== got_want.c)
            flag_error($sformatf("octet_c got %0d want %0d", octet_c, got_want.c));
          if (octet_d !== got_want.d)
            flag_error($sformatf("octet_d got %0d want %0d", octet_d, got_want.d));
          if (port_out !== got_want.port)
            flag_error($sformatf("port_out got %0d want %0d", port_out, got_want.port));
          if (status !== got_want.st)
            flag_error($sformatf("status got %0d want %0d", status, got_want.st));
          case (got_want.st)
            ST_OK: ok_cnt++;
            ST_NODOT: nodot_cnt++;
            default: range_cnt++;
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("dotted_quad_port_parser_core test failed");
      $finish;
    end
  end

  task add_char(input logic [CHAR_W-1:0] ch);
    char_word_t w;
    w.ch = ch;
    w.lead = lead_pending;
    lead_pending = 1'b0;
    char_q.push_back(w);
    stim_cnt++;
  endtask

  task add_stray(input logic [CHAR_W-1:0] ch, input logic lead);
    char_word_t w;
    w.ch = ch;
    w.lead = lead;
    char_q.push_back(w);
  endtask

  task push_text(input string s, input logic lead);
    lead_pending = lead;
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  function automatic logic [CHAR_W-1:0] any_non_digit();
    int r;
    logic [CHAR_W-1:0] c;
    r = $urandom_range(99);
    if (r < 15) return 8'h00;
    if (r < 25) return CH_COLON;
    if (r < 32) return CH_DOT;
    do c = CHAR_W'($urandom_range(0, 255)); while (c >= CH_ZERO && c <= CH_NINE);
    return c;
  endfunction

  task add_field(input int maxv);
    int r;
    string s;
    r = $urandom_range(99);
    s = "";
    if (r < 8) begin
      s = "";
    end else if (r < 18) begin
      repeat ($urandom_range(4, 7)) add_char(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
    end else if (r < 25) begin
      add_char(CH_ZERO);
      s = $sformatf("%0d", $urandom_range(0, maxv));
    end else if (r < 35) begin
      s = $sformatf("%0d", $urandom_range(0, 1) ? maxv : 0);
    end else if (r < 42 && maxv == OCT_MAX) begin
      s = $sformatf("%0d", $urandom_range(256, 999));
    end else begin
      s = $sformatf("%0d", $urandom_range(0, maxv));
    end
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  task add_address();
    logic [CHAR_W-1:0] sep;
    lead_pending = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(99) < 3) return;
      add_field(OCT_MAX);
      if (i < 3) begin
        sep = ($urandom_range(99) < 95) ? CH_DOT : any_non_digit();
        add_char(sep);
        if (sep != CH_DOT) return;
      end
    end
    sep = ($urandom_range(99) < 55) ? CH_COLON : any_non_digit();
    add_char(sep);
    if (sep == CH_COLON) begin
      if ($urandom_range(99) < 3) return;
      add_field(16'hFFFF);
      add_char(any_non_digit());
    end
  endtask

  task fill_random(input int count);
    int goal;
    goal = stim_cnt + count;
    while (stim_cnt < goal) begin
      if ($urandom_range(99) < 10) begin
        add_stray(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else begin
        add_address();
        if ($urandom_range(99) < 30)
          repeat ($urandom_range(1, 3)) add_stray(CHAR_W'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  task set_default_port(input logic [ACC_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    port_default = v;
  endtask

  task drain();
    @(posedge clk);
    while (char_q.size() != 0 || in_valid || addr_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_default_port(16'hFFFF);
    push_text("A", 1'b0);
    push_text("...", 1'b1);
    add_char(8'hFF);
    push_text("9/", 1'b1);
    push_text("300:", 1'b1);
    push_text("256...:", 1'b1);
    push_text("7.", 1'b1);
    push_text(":", 1'b1);
    push_text("...:", 1'b1);
    add_char(8'h00);
    drain();

    for (int m = 0; m < 4; m++) begin
      send_idle_pct = (m == 1) ? 56 : (m == 3) ? 29 : 0;
      recv_stall_pct = (m == 2) ? 56 : (m == 3) ? 29 : 0;
      case (m)
        0: set_default_port(16'h0000);
        1: set_default_port(ACC_W'($urandom_range(1, 16'hFFFE)));
        2: set_default_port(16'h0001);
        default: set_default_port(16'hFFFF);
      endcase
      fill_random(WORDS_PER_MODE);
      drain();
    end

    if (addr_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", addr_q.size()));
    $display("%0d characters parsed over 4 flow-control modes and 5 default-port writes",
             char_cnt);
    $display("results: %0d ok, %0d missing dot, %0d field out of range",
             ok_cnt, nodot_cnt, range_cnt);
    if (err_cnt == 0) begin
      $display("dotted_quad_port_parser_core test passed");
    end else begin
      $display("dotted_quad_port_parser_core test failed");
    end
    $finish;
  end

endmodule
